[hw/rtl/ggs_pkg.sv]
// Package: fixed-point constants, tables and helper types for the geodesic grid section lookup.
`timescale 1ns / 1ps
package ggs_pkg;

    // Coefficient codes: 0 zero, 1 +KA, 2 +KB, 3 +KC, 4 +KD, 5 +KE, 9..13 negatives.
    typedef logic [3:0] t_kcode;

    localparam t_kcode K0 = 4'd0;
    localparam t_kcode PA = 4'd1;
    localparam t_kcode PB = 4'd2;
    localparam t_kcode PC = 4'd3;
    localparam t_kcode PD = 4'd4;
    localparam t_kcode PE = 4'd5;
    localparam t_kcode NA = 4'd9;
    localparam t_kcode NB = 4'd10;
    localparam t_kcode NC = 4'd11;
    localparam t_kcode ND = 4'd12;
    localparam t_kcode NE = 4'd13;

    typedef t_kcode t_mat [0:8];

    function automatic t_mat face_mat(input logic [3:0] f);
        t_mat m;
        unique case (f)
            4'd0: m = '{NB, PC, PA, K0, K0, ND, NB, NC, PA};
            4'd1: m = '{NA, PB, NC, NC, NA, PB, PB, NC, NA};
            4'd2: m = '{ND, K0, K0, PA, NB, NC, PA, NB, PC};
            4'd3: m = '{NC, PA, NB, K0, ND, K0, PC, PA, NB};
            4'd4: m = '{NA, NB, NC, NA, NB, PC, PD, K0, K0};
            4'd5: m = '{NB, NC, NA, PA, PB, NC, PC, NA, PB};
            4'd6: m = '{PB, NC, PA, K0, K0, ND, PB, PC, PA};
            4'd7: m = '{PA, NB, NC, PC, PA, PB, NB, PC, NA};
            4'd8: m = '{PC, NA, NB, K0, PD, K0, NC, NA, NB};
            4'd9: m = '{PB, PC, NA, NC, PA, PB, NA, NB, NC};
            default: m = '{K0, K0, K0, K0, K0, K0, K0, K0, K0};
        endcase
        return m;
    endfunction

    function automatic t_mat mid_mat(input logic [3:0] f);
        t_mat m;
        unique case (f)
            4'd0: m = '{K0, PE, ND, K0, NE, ND, ND, K0, PE};
            4'd1: m = '{NE, PD, K0, K0, NE, PD, PD, K0, NE};
            4'd2: m = '{ND, K0, NE, PE, ND, K0, ND, K0, PE};
            4'd3: m = '{NE, ND, K0, PE, ND, K0, K0, PE, ND};
            4'd4: m = '{NE, ND, K0, PD, K0, PE, PD, K0, NE};
            4'd5: m = '{ND, K0, NE, PE, PD, K0, K0, NE, PD};
            4'd6: m = '{K0, NE, ND, K0, PE, ND, PD, K0, PE};
            4'd7: m = '{PE, ND, K0, K0, PE, PD, ND, K0, NE};
            4'd8: m = '{PE, PD, K0, NE, PD, K0, K0, NE, ND};
            4'd9: m = '{K0, PE, PD, NE, ND, K0, PD, K0, NE};
            default: m = '{K0, K0, K0, K0, K0, K0, K0, K0, K0};
        endcase
        return m;
    endfunction

    typedef struct packed {
        logic [4:0] c0, c1, c2, c3, c4;
        logic [1:0] v0c0, v1c1, v2c1, v4c4, v0c4;
    } t_umb;

    function automatic t_umb umb_entry(input logic [2:0] idx);
        t_umb e;
        unique case (idx)
            3'd0, 3'd3: e = '{5'd9, 5'd8, 5'd7, 5'd12, 5'd14, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2};
            3'd1, 3'd4: e = '{5'd1, 5'd2, 5'd4, 5'd5, 5'd3, 2'd0, 2'd0, 2'd2, 2'd2, 2'd0};
            default:    e = '{5'd16, 5'd15, 5'd13, 5'd18, 5'd17, 2'd2, 2'd2, 2'd0, 2'd2,
                              2'd1};
        endcase
        if (idx > 3'd2) begin
            e.c0 = (e.c0 >= 5'd10) ? e.c0 - 5'd10 : e.c0 + 5'd10;
            e.c1 = (e.c1 >= 5'd10) ? e.c1 - 5'd10 : e.c1 + 5'd10;
            e.c2 = (e.c2 >= 5'd10) ? e.c2 - 5'd10 : e.c2 + 5'd10;
            e.c3 = (e.c3 >= 5'd10) ? e.c3 - 5'd10 : e.c3 + 5'd10;
            e.c4 = (e.c4 >= 5'd10) ? e.c4 - 5'd10 : e.c4 + 5'd10;
        end
        return e;
    endfunction

    // Control between the face stage and the sub-triangle stage.
    typedef struct packed {
        logic       vld;
        logic       found;
        logic [4:0] face;
        logic       incl;
    } t_face_ctl;

endpackage

[hw/rtl/ggs_if.sv]
// Interfaces: valid/ready channels for input vectors and section results.
`timescale 1ns / 1ps
interface ggs_in_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;
    logic                          inclusive;
    modport source (output valid, vec_x, vec_y, vec_z, inclusive, input ready);
    modport sink (input valid, vec_x, vec_y, vec_z, inclusive, output ready);
endinterface

interface ggs_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] section_index;
    logic       valid_res;
    modport source (output valid, section_index, valid_res, input ready);
    modport sink (input valid, section_index, valid_res, output ready);
endinterface

[hw/rtl/ggs_xform.sv]
// Registered 3x3 basis change with a coded constant matrix, optional negation.
`timescale 1ns / 1ps
module ggs_xform import ggs_pkg::*; #(
    parameter int COORD_WIDTH    = 24,
    parameter int COEF_FRAC_BITS = 16,
    parameter int CW             = COORD_WIDTH + COEF_FRAC_BITS + 4
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  t_mat                          i_mat,
    input  logic                          i_neg,
    input  logic signed [COORD_WIDTH-1:0] i_v [3],
    output logic signed [CW-1:0]          o_w [3]
);
    localparam int F = COEF_FRAC_BITS;
    localparam longint SC = 64'd1 << F;
    localparam logic signed [F+2:0] KA = (F+3)'((190983 * SC + 500000) / 1000000);
    localparam logic signed [F+2:0] KB = (F+3)'((309017 * SC + 500000) / 1000000);
    localparam logic signed [F+2:0] KC = (F+3)'((500000 * SC + 500000) / 1000000);
    localparam logic signed [F+2:0] KD = (F+3)'((618034 * SC + 500000) / 1000000);
    localparam logic signed [F+2:0] KE = (F+3)'(SC);

    function automatic logic signed [F+2:0] kval(input t_kcode c);
        logic signed [F+2:0] k;
        unique case (c[2:0])
            3'd1: k = KA;
            3'd2: k = KB;
            3'd3: k = KC;
            3'd4: k = KD;
            3'd5: k = KE;
            default: k = '0;
        endcase
        return c[3] ? -k : k;
    endfunction

    logic signed [CW-1:0] n_w [3];
    logic signed [CW-1:0] s;

    always_comb begin
        s = '0;
        for (int r = 0; r < 3; r++) begin
            s = CW'(kval(i_mat[3*r]) * i_v[0]) + CW'(kval(i_mat[3*r+1]) * i_v[1])
              + CW'(kval(i_mat[3*r+2]) * i_v[2]);
            n_w[r] = i_neg ? -s : s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w <= n_w;
        end
    end
endmodule

[hw/rtl/geodesic_grid_section_top.sv]
// Top level: pipelined 80-section geodesic grid lookup.
`timescale 1ns / 1ps
// Maps a direction vector to one of 80 sections (4 * face + sub-triangle) of an
// icosahedral grid. Fully pipelined: one beat in per cycle while the output is not
// stalled. Each beat passes through seven register stages: input capture, three
// basis changes, two decision stages and the output register.
// A stalled output holds the whole pipeline; no beat is dropped. Coefficients
// within the configured tolerance (r_tol) of zero count as zero; non-inclusive boundary hits and
// null vectors come out with valid_res 0.
module geodesic_grid_section_top import ggs_pkg::*; #(
    parameter int COORD_WIDTH    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    ggs_in_if.sink      i_in,
    ggs_out_if.source   o_out
);
    localparam int CW = COORD_WIDTH + COEF_FRAC_BITS + 4;
    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [CW-1:0] t_coef;

    logic [15:0] r_tol;
    logic        en;
    logic [6:0]  r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tol <= 16'd1;
        else if (i_cfg_we) r_tol <= i_cfg_wdata;
    end

    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    function automatic logic nz(input t_coef c, input logic [15:0] t);
        t_coef tt;
        tt = t_coef'({1'b0, t});
        return (c >= -tt) && (c <= tt);
    endfunction

    // stage 0: capture input
    t_coord r0_v [3];
    logic   r0_incl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[5:0], i_in.valid};
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_v    <= '{i_in.vec_x, i_in.vec_y, i_in.vec_z};
            r0_incl <= i_in.inclusive;
        end
    end

    // stage 1: face-0 coefficients
    t_coef  w1 [3];
    t_coord r1_v [3];
    logic   r1_incl;
    ggs_xform #(.COORD_WIDTH(COORD_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .CW(CW)) u_x1 (
        .i_clk(i_clk), .i_en(en), .i_mat(face_mat(4'd0)), .i_neg(1'b0),
        .i_v(r0_v), .o_w(w1));
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_v <= r0_v;
            r1_incl <= r0_incl;
        end
    end

    // stage 2 decision: classify, choose umbrella and candidate face
    logic       n2_done, n2_found;
    logic [4:0] n2_face;
    logic [2:0] n2_um;
    logic [1:0] n2_br;
    logic [4:0] n2_cand;
    t_coef      u [3];
    t_coef      wn [3];
    t_umb       ue;
    always_comb begin
        int zeros, bal;
        zeros = 0; bal = 0;
        n2_done = 1'b0; n2_found = 1'b0; n2_face = '0; n2_um = '0;
        n2_br = '0; n2_cand = '0;
        wn = w1;
        for (int r = 0; r < 3; r++) begin
            if (nz(w1[r], r_tol)) zeros++;
            else if (w1[r] > 0) bal++;
            else bal--;
        end
        if (bal == 3) begin
            n2_done = 1'b1; n2_found = 1'b1; n2_face = 5'd0;
        end else if (bal == -3) begin
            n2_done = 1'b1; n2_found = 1'b1; n2_face = 5'd10;
        end else if (bal == 2) begin
            n2_done = 1'b1; n2_found = r1_incl; n2_face = 5'd0;
        end else if (bal == -2) begin
            n2_done = 1'b1; n2_found = r1_incl; n2_face = 5'd10;
        end else if (bal == -1) begin
            if (zeros == 2) begin
                n2_done = 1'b1; n2_found = r1_incl; n2_face = 5'd10;
            end else if (!nz(w1[0], r_tol) && w1[0] > 0) n2_um = 3'd4;
            else if (!nz(w1[1], r_tol) && w1[1] > 0) n2_um = 3'd5;
            else n2_um = 3'd3;
            for (int r = 0; r < 3; r++) wn[r] = -w1[r];
        end else begin
            if (bal == 1 && zeros == 2) begin
                n2_done = 1'b1; n2_found = r1_incl; n2_face = 5'd0;
            end else if (bal == 0 && zeros == 3) begin
                n2_done = 1'b1;
            end else if (!nz(w1[0], r_tol) && w1[0] < 0) n2_um = 3'd1;
            else if (!nz(w1[1], r_tol) && w1[1] < 0) n2_um = 3'd2;
            else n2_um = 3'd0;
        end
        unique case (n2_um)
            3'd0, 3'd3: u = '{wn[0], wn[1], -wn[2]};
            3'd1, 3'd4: u = '{wn[1], wn[2], -wn[0]};
            default:    u = '{wn[2], wn[0], -wn[1]};
        endcase
        ue = umb_entry(n2_um);
        if (nz(u[0] - u[1], r_tol)) begin
            n2_br = 2'd0; n2_cand = ue.c0;
        end else if (u[1] > u[0]) begin
            n2_br = 2'd1; n2_cand = ue.c1;
        end else begin
            n2_br = 2'd2; n2_cand = ue.c4;
        end
    end

    t_coord     r2_v [3];
    logic       r2_incl, r2_done, r2_found, r2_ult;
    logic [4:0] r2_face, r2_cand;
    logic [2:0] r2_um;
    logic [1:0] r2_br;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_v <= r1_v; r2_incl <= r1_incl; r2_done <= n2_done;
            r2_found <= n2_found; r2_face <= n2_face; r2_cand <= n2_cand;
            r2_um <= n2_um; r2_br <= n2_br; r2_ult <= u[0] < u[1];
        end
    end

    // stage 3: candidate face coefficients
    t_coef  w3 [3];
    t_coord r3_v [3];
    logic   r3_incl, r3_done, r3_found, r3_ult;
    logic [4:0] r3_face, r3_cand;
    logic [2:0] r3_um;
    logic [1:0] r3_br;
    logic [3:0] cmod;
    assign cmod = (r2_cand >= 5'd10) ? 4'(r2_cand - 5'd10) : r2_cand[3:0];
    ggs_xform #(.COORD_WIDTH(COORD_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .CW(CW)) u_x2 (
        .i_clk(i_clk), .i_en(en), .i_mat(face_mat(cmod)), .i_neg(r2_cand >= 5'd10),
        .i_v(r2_v), .o_w(w3));
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_v <= r2_v; r3_incl <= r2_incl; r3_done <= r2_done;
            r3_found <= r2_found; r3_face <= r2_face; r3_cand <= r2_cand;
            r3_um <= r2_um; r3_br <= r2_br; r3_ult <= r2_ult;
        end
    end

    // stage 3 decision: resolve face within umbrella
    t_face_ctl n4;
    t_umb      e3;
    t_coef     xa, xb;
    always_comb begin
        e3 = umb_entry(r3_um);
        n4.vld = 1'b1; n4.incl = r3_incl; n4.found = 1'b1; n4.face = r3_cand;
        xa = '0; xb = '0;
        if (r3_done) begin
            n4.found = r3_found; n4.face = r3_face;
        end else begin
            unique case (r3_br)
                2'd0: begin
                    xa = w3[e3.v0c0];
                    if (nz(xa, r_tol)) n4.found = r3_incl;
                    else if (xa < 0) begin
                        n4.found = r3_incl; n4.face = r3_ult ? e3.c3 : e3.c2;
                    end
                end
                2'd1: begin
                    xa = w3[e3.v1c1]; xb = w3[e3.v2c1];
                    if (nz(xa, r_tol)) begin
                        n4.found = r3_incl; n4.face = (xa < 0) ? e3.c2 : e3.c1;
                    end else if (xa < 0) n4.face = e3.c2;
                    else if (nz(xb, r_tol)) begin
                        n4.found = r3_incl; n4.face = (xb > 0) ? e3.c1 : e3.c0;
                    end else if (xb < 0) n4.face = e3.c0;
                end
                default: begin
                    xa = w3[e3.v4c4]; xb = w3[e3.v0c4];
                    if (nz(xa, r_tol)) begin
                        n4.found = r3_incl; n4.face = (xa < 0) ? e3.c0 : e3.c4;
                    end else if (xa < 0) n4.face = e3.c0;
                    else if (nz(xb, r_tol)) begin
                        n4.found = r3_incl; n4.face = (xb > 0) ? e3.c4 : e3.c3;
                    end else if (xb < 0) n4.face = e3.c3;
                end
            endcase
        end
    end

    t_face_ctl r4;
    t_coord    r4_v [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4 <= n4; r4_v <= r3_v;
        end
    end

    // stage 4: middle-triangle coefficients
    t_coef      w5 [3];
    t_face_ctl  r5;
    logic [3:0] fmod;
    assign fmod = (r4.face >= 5'd10) ? 4'(r4.face - 5'd10) : r4.face[3:0];
    ggs_xform #(.COORD_WIDTH(COORD_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .CW(CW)) u_x3 (
        .i_clk(i_clk), .i_en(en), .i_mat(mid_mat(fmod)), .i_neg(r4.face >= 5'd10),
        .i_v(r4_v), .o_w(w5));
    always_ff @(posedge i_clk) begin
        if (en) r5 <= r4;
    end

    // stage 5: sub-triangle pick into output register
    logic [6:0] n_idx;
    logic       n_res;
    logic [1:0] sub;
    logic       z0, z1, z2;
    always_comb begin
        z0 = nz(w5[0], r_tol); z1 = nz(w5[1], r_tol); z2 = nz(w5[2], r_tol);
        if (!z0 && w5[0] < 0) sub = 2'd3;
        else if (!z1 && w5[1] < 0) sub = 2'd1;
        else if (!z2 && w5[2] < 0) sub = 2'd2;
        else sub = 2'd0;
        n_res = r5.found && !((z0 || z1 || z2) && !r5.incl);
        n_idx = n_res ? 7'({r5.face, 2'b00}) + 7'(sub) : 7'd0;
    end

    logic [6:0] r_idx;
    logic       r_res;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx <= n_idx; r_res <= n_res;
        end
    end
    assign o_out.valid         = r_v[6];
    assign o_out.section_index = r_idx;
    assign o_out.valid_res     = r_res;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.section_index < 7'd80) else $error("index range");
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.valid_res) |-> o_out.section_index == 7'd0)
        else $error("invalid beat with nonzero index");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.section_index)))
        else $error("output beat lost");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready) else $error("stall without pending beat");
endmodule
